// File: hdl/packet_buffer_tail_drop_sim_unit_defines.svh
// Assertion macros shared by the packet buffer checker.
`ifndef PACKET_BUFFER_TAIL_DROP_SIM_UNIT_DEFINES_SVH
`define PACKET_BUFFER_TAIL_DROP_SIM_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define PBTD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define PBTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/pbtd_pkg.sv
// Shared constants, types and index helpers for the packet buffer.
package pbtd_pkg;

  localparam int BUF_DEPTH = 16;
  localparam int PTR_W     = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
  localparam int SUM_W     = CNT_W + 1;
  localparam int TIME_W    = 33;
  localparam int WORD_W    = 32;
  localparam int LIMIT_W   = 5;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

  // Result of one item
  typedef struct packed {
    logic              dropped;
    logic [TIME_W-1:0] start_time;
  } pbtd_res_t;

  // Ring memory access request
  typedef struct packed {
    logic              re;
    logic [PTR_W-1:0]  raddr;
    logic              we;
    logic [PTR_W-1:0]  waddr;
    logic [TIME_W-1:0] wdata;
  } pbtd_mem_req_t;

  // (ptr + n) mod BUF_DEPTH, valid for ptr < BUF_DEPTH and n <= BUF_DEPTH
  function automatic logic [PTR_W-1:0] wrap_add(logic [PTR_W-1:0] ptr,
                                                logic [CNT_W-1:0] n);
    logic [SUM_W-1:0] s;
    s = SUM_W'(ptr) + SUM_W'(n);
    if (s >= SUM_W'(BUF_DEPTH)) s = s - SUM_W'(BUF_DEPTH);
    return PTR_W'(s);
  endfunction

endpackage

// File: hdl/packet_buffer_tail_drop_sim_unit.sv
// An accepted item goes straight to S_DECIDE when the ring is empty; otherwise the head
// entry is read and S_CHECK retires finished entries, one registered ring read per entry
// checked, before S_DECIDE drops or appends and loads the result register. The next item
// waits for the sequencer to return to idle and for the result to go out.
// Reset (rst_n low, synchronous): ring empty, head 0, last finish 0, limit 16,
// no result pending. Ring contents are not cleared; only written entries are read.
module packet_buffer_tail_drop_sim_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [pbtd_pkg::WORD_W-1:0]      in_arrival_time,
  input  logic [pbtd_pkg::WORD_W-1:0]      in_duration,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_dropped,
  output logic [pbtd_pkg::TIME_W-1:0]      out_start_time,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pbtd_pkg::LIMIT_W-1:0]     cfg_data
);
  import pbtd_pkg::*;

  logic [LIMIT_W-1:0] limit_r;
  logic [CNT_W-1:0]   eff_limit;
  logic               out_valid_r;
  pbtd_res_t          out_res_r;
  pbtd_mem_req_t      mem_req;
  logic [TIME_W-1:0]  mem_rdata;
  logic               res_valid;
  pbtd_res_t          res;
  logic               out_free;

  // limit register, saturated to the ring depth
  assign cfg_ready = 1'b1;
  assign eff_limit = (32'(limit_r) > 32'(BUF_DEPTH)) ? CNT_W'(BUF_DEPTH) : CNT_W'(limit_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit_r <= cfg_data;
    end
  end

  // result register
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (res_valid) out_res_r <= res;
  end

  assign out_valid      = out_valid_r;
  assign out_dropped    = out_res_r.dropped;
  assign out_start_time = out_res_r.start_time;

  pbtd_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_arrival_time (in_arrival_time),
    .in_duration     (in_duration),
    .out_free        (out_free),
    .eff_limit       (eff_limit),
    .mem_rdata       (mem_rdata),
    .mem_req         (mem_req),
    .res_valid       (res_valid),
    .res             (res)
  );

  // finish-tick ring
  pbtd_ram #(
    .WIDTH (TIME_W),
    .DEPTH (BUF_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

endmodule

// File: hdl/pbtd_ram.sv
// Generic single-clock RAM, one write and one registered read port.
module pbtd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/pbtd_core.sv
// Sequencer: retires finished entries from the ring, then drops or appends.
module pbtd_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pbtd_pkg::WORD_W-1:0]   in_arrival_time,
  input  logic [pbtd_pkg::WORD_W-1:0]   in_duration,
  input  logic                          out_free,
  input  logic [pbtd_pkg::CNT_W-1:0]    eff_limit,
  input  logic [pbtd_pkg::TIME_W-1:0]   mem_rdata,
  output pbtd_pkg::pbtd_mem_req_t       mem_req,
  output logic                          res_valid,
  output pbtd_pkg::pbtd_res_t           res
);
  import pbtd_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_CHECK, S_DECIDE} state_t;

  state_t            state_r, state_nxt;
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]  occ_r, occ_nxt;
  logic [TIME_W-1:0] last_r, last_nxt;
  logic [WORD_W-1:0] arr_r, arr_nxt;
  logic [WORD_W-1:0] dur_r, dur_nxt;

  logic [PTR_W-1:0]  head_inc;
  logic [TIME_W-1:0] arr_ext;
  logic [TIME_W-1:0] start;
  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] finish;

  assign head_inc = wrap_add(head_r, CNT_W'(1));
  assign arr_ext  = {1'b0, arr_r};
  assign start    = (arr_ext > last_r) ? arr_ext : last_r;
  assign sum      = {1'b0, start} + (TIME_W + 1)'(dur_r);
  // saturate finish tick at the top of the time range
  assign finish   = sum[TIME_W] ? '1 : sum[TIME_W-1:0];

  assign in_ready = (state_r == S_IDLE) && out_free;

  // next-state and memory request logic
  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    occ_nxt   = occ_r;
    last_nxt  = last_r;
    arr_nxt   = arr_r;
    dur_nxt   = dur_r;
    mem_req   = '0;
    res_valid = 1'b0;
    res       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          arr_nxt = in_arrival_time;
          dur_nxt = in_duration;
          if (occ_r != '0) begin
            mem_req.re    = 1'b1;
            mem_req.raddr = head_r;
            state_nxt     = S_CHECK;
          end else begin
            state_nxt = S_DECIDE;
          end
        end
      end
      S_CHECK: begin
        // oldest entry finished by arrival: pop it, look at the next one
        if (mem_rdata <= arr_ext) begin
          head_nxt = head_inc;
          occ_nxt  = occ_r - CNT_W'(1);
          if (occ_r > CNT_W'(1)) begin
            mem_req.re    = 1'b1;
            mem_req.raddr = head_inc;
          end else begin
            state_nxt = S_DECIDE;
          end
        end else begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        res_valid = 1'b1;
        if (occ_r >= eff_limit) begin
          res.dropped = 1'b1;
        end else begin
          res.start_time = start;
          mem_req.we     = 1'b1;
          mem_req.waddr  = wrap_add(head_r, occ_r);
          mem_req.wdata  = finish;
          occ_nxt        = occ_r + CNT_W'(1);
          last_nxt       = finish;
        end
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and item registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      occ_r   <= '0;
      last_r  <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      occ_r   <= occ_nxt;
      last_r  <= last_nxt;
    end
    arr_r <= arr_nxt;
    dur_r <= dur_nxt;
  end

endmodule

// File: hdl/pbtd_checker.sv
// Port-level checker for the packet buffer, bound to the top level.
`include "packet_buffer_tail_drop_sim_unit_defines.svh"

module pbtd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_dropped,
  input logic [pbtd_pkg::TIME_W-1:0] out_start_time
);
  import pbtd_pkg::*;

  // a dropped packet reports start tick zero
  `PBTD_ASSERT_NOW(a_drop_zero, out_valid && out_dropped, out_start_time == '0, "dropped item with nonzero start")

  // a stalled result holds
  `PBTD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_dropped) && $stable(out_start_time), "stalled result changed")

  // one item at a time: no accept in the cycle after an accept
  `PBTD_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "item accepted while busy")

  // an item is only taken when the result slot is free or draining
  `PBTD_ASSERT_NOW(a_slot_free, in_ready, !out_valid || out_ready, "ready while result slot blocked")

endmodule

bind packet_buffer_tail_drop_sim_unit pbtd_checker u_pbtd_checker (.*);
